// ----- rtl/ccsm_pkg.sv -----
// Shared codes, types and helpers for the clock/calendar set-menu core.
package ccsm_pkg;

    localparam logic [2:0] OP_DOWN    = 3'd0;
    localparam logic [2:0] OP_UP      = 3'd1;
    localparam logic [2:0] OP_ADVANCE = 3'd2;
    localparam logic [2:0] OP_LOAD    = 3'd3;
    localparam logic [2:0] OP_START   = 3'd4;

    localparam logic [2:0] FIELD_HOUR   = 3'd0;
    localparam logic [2:0] FIELD_MINUTE = 3'd1;
    localparam logic [2:0] FIELD_SECOND = 3'd2;
    localparam logic [2:0] FIELD_YEAR   = 3'd3;
    localparam logic [2:0] FIELD_MONTH  = 3'd4;
    localparam logic [2:0] FIELD_DAY    = 3'd5;
    localparam logic [2:0] FIELD_IDLE   = 3'd6;

    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] MINSEC_MAX = 7'd59;
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [6:0] MONTH_MAX  = 7'd12;

    // Result of one step, before the decimal split.
    typedef struct packed {
        logic [2:0] field;
        logic [6:0] shown;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic       finished;
    } t_step_res;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        begin
            len = 5'd31;
            if (month == 4'd2) begin
                len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            end else if (month == 4'd4 || month == 4'd6 || month == 4'd9 || month == 4'd11) begin
                len = 5'd30;
            end
            return len;
        end
    endfunction

    function automatic logic [6:0] field_lower(input logic [2:0] field);
        return (field == FIELD_MONTH || field == FIELD_DAY) ? 7'd1 : 7'd0;
    endfunction

    function automatic logic [6:0] field_upper(input logic [2:0] field,
                                               input logic [4:0] mlen);
        logic [6:0] hi;
        begin
            unique case (field)
                FIELD_HOUR:                begin hi = HOUR_MAX; end
                FIELD_MINUTE, FIELD_SECOND: begin hi = MINSEC_MAX; end
                FIELD_YEAR:                begin hi = YEAR_MAX; end
                FIELD_MONTH:               begin hi = MONTH_MAX; end
                default:                   begin hi = {2'b00, mlen}; end
            endcase
            return hi;
        end
    endfunction

endpackage

// ----- rtl/ccsm_update.sv -----
// Held time/date registers, menu position and the per-transaction update logic.
module ccsm_update
    import ccsm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [2:0] i_opcode,
    input  logic [2:0] i_load_field,
    input  logic [6:0] i_load_value,
    output t_step_res  o_res
);

    logic [2:0] r_field,  n_field;
    logic [4:0] r_hour,   n_hour;
    logic [5:0] r_minute, n_minute;
    logic [5:0] r_second, n_second;
    logic [6:0] r_year,   n_year;
    logic [3:0] r_month,  n_month;
    logic [4:0] r_day,    n_day;

    logic       wr_en;
    logic [2:0] wr_field;
    logic [6:0] wr_val;
    logic       fin;
    logic       active;
    logic [6:0] cur;
    logic [4:0] cur_len;
    logic [4:0] new_len;
    logic [6:0] lo;
    logic [6:0] hi;
    logic [6:0] shown;

    assign active  = (r_field < FIELD_IDLE);
    assign cur_len = month_len(r_month, r_year);

    always_comb begin
        unique case (r_field)
            FIELD_HOUR:   begin cur = {2'b00, r_hour}; end
            FIELD_MINUTE: begin cur = {1'b0, r_minute}; end
            FIELD_SECOND: begin cur = {1'b0, r_second}; end
            FIELD_YEAR:   begin cur = r_year; end
            FIELD_MONTH:  begin cur = {3'b000, r_month}; end
            default:      begin cur = {2'b00, r_day}; end
        endcase
    end

    // Decide which field gets written and with what.
    always_comb begin
        wr_en    = 1'b0;
        wr_field = r_field;
        wr_val   = cur;
        fin      = 1'b0;
        n_field  = r_field;
        lo       = field_lower(r_field);
        hi       = field_upper(r_field, cur_len);
        case (i_opcode)
            OP_DOWN: begin
                if (active && cur > lo) begin
                    wr_en  = 1'b1;
                    wr_val = cur - 7'd1;
                end
            end
            OP_UP: begin
                if (active && cur < hi) begin
                    wr_en  = 1'b1;
                    wr_val = cur + 7'd1;
                end
            end
            OP_ADVANCE: begin
                if (active) begin
                    if (r_field == FIELD_DAY) begin
                        n_field = FIELD_IDLE;
                        fin     = 1'b1;
                    end else begin
                        n_field = r_field + 3'd1;
                    end
                end
            end
            OP_LOAD: begin
                if (i_load_field < FIELD_IDLE) begin
                    lo       = field_lower(i_load_field);
                    hi       = field_upper(i_load_field, cur_len);
                    wr_en    = 1'b1;
                    wr_field = i_load_field;
                    if (i_load_value < lo) begin
                        wr_val = lo;
                    end else if (i_load_value > hi) begin
                        wr_val = hi;
                    end else begin
                        wr_val = i_load_value;
                    end
                end
            end
            OP_START: begin
                n_field = FIELD_HOUR;
            end
            default: begin
            end
        endcase
    end

    // Apply the write, then pull the day back inside the month.
    always_comb begin
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        if (wr_en) begin
            unique case (wr_field)
                FIELD_HOUR:   begin n_hour   = wr_val[4:0]; end
                FIELD_MINUTE: begin n_minute = wr_val[5:0]; end
                FIELD_SECOND: begin n_second = wr_val[5:0]; end
                FIELD_YEAR:   begin n_year   = wr_val; end
                FIELD_MONTH:  begin n_month  = wr_val[3:0]; end
                default:      begin n_day    = wr_val[4:0]; end
            endcase
        end
        new_len = month_len(n_month, n_year);
        if (n_day > new_len) begin
            n_day = new_len;
        end
    end

    always_comb begin
        unique case (n_field)
            FIELD_HOUR:   begin shown = {2'b00, n_hour}; end
            FIELD_MINUTE: begin shown = {1'b0, n_minute}; end
            FIELD_SECOND: begin shown = {1'b0, n_second}; end
            FIELD_YEAR:   begin shown = n_year; end
            FIELD_MONTH:  begin shown = {3'b000, n_month}; end
            FIELD_DAY:    begin shown = {2'b00, n_day}; end
            default:      begin shown = 7'd0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field  <= FIELD_IDLE;
            r_hour   <= 5'd0;
            r_minute <= 6'd0;
            r_second <= 6'd0;
            r_year   <= 7'd0;
            r_month  <= 4'd1;
            r_day    <= 5'd1;
        end else if (i_step) begin
            r_field  <= n_field;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
        end
    end

    assign o_res.field    = n_field;
    assign o_res.shown    = shown;
    assign o_res.hour     = n_hour;
    assign o_res.minute   = n_minute;
    assign o_res.second   = n_second;
    assign o_res.year     = n_year;
    assign o_res.month    = n_month;
    assign o_res.day      = n_day;
    assign o_res.finished = fin;

endmodule

// ----- rtl/ccsm_digits.sv -----
// Splits a value of 0..99 into tens and ones decimal digits.
module ccsm_digits
    import ccsm_pkg::*;
(
    input  logic [6:0] i_value,
    output logic [3:0] o_tens,
    output logic [3:0] o_ones
);

    logic [14:0] prod;
    logic [6:0]  tens_x10;

    // x*205 >> 11 equals x/10 over 0..99
    assign prod     = {8'd0, i_value} * 15'd205;
    assign o_tens   = prod[14:11];
    assign tens_x10 = {o_tens, 3'b000} + {2'b00, o_tens, 1'b0};
    assign o_ones   = 4'(i_value - tens_x10);

endmodule

// ----- rtl/clock_calendar_set_menu_core.sv -----
// Top level of the clock/calendar set-menu core.
//
// Usage: one command transaction enters on the slave stream; tuser carries the
// opcode (down, up, advance, load, start) and tdata the load field and value.
// Each command gives exactly one result on the master stream: tuser is the
// active field (6 when idle), tdata the shown value, its two decimal digits
// and all six held values, tlast the finished flag raised on the advance that
// leaves the day field.
// Path: a command taken on the slave side passes through the input register,
// then the result register, before it is presented on the master side.
// Throughput: one command per cycle while the receiver takes results; the held
// values update in the cycle the command moves from the input register to the result register.
// A stalled receiver holds the result register; the input register still
// takes one more command, after which s_axis_tready drops until the result
// is taken.
// Reset: menu idle, time 00:00:00, date year 0, month 1, day 1; both
// registers empty.
module clock_calendar_set_menu_core
    import ccsm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // load_field[2:0], load_value[9:3], zero[15:10]
    input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // shown_value[6:0], tens_digit[10:7], ones_digit[14:11],
                                       // hour_out[19:15], minute_out[25:20], second_out[31:26],
                                       // year_out[38:32], month_out[42:39], day_out[47:43]
    output logic [2:0]  m_axis_tuser,  // active_field[2:0]
    output logic        m_axis_tlast   // finished
);

    logic        r_in_valid;
    logic [2:0]  r_in_op;
    logic [2:0]  r_in_field;
    logic [6:0]  r_in_value;
    logic        r_out_valid;
    logic [47:0] r_out_data;
    logic [2:0]  r_out_field;
    logic        r_out_last;

    logic        step;
    t_step_res   res;
    logic [3:0]  tens;
    logic [3:0]  ones;

    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;

    ccsm_update u_update (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_opcode     (r_in_op),
        .i_load_field (r_in_field),
        .i_load_value (r_in_value),
        .o_res        (res)
    );

    ccsm_digits u_digits (
        .i_value (res.shown),
        .o_tens  (tens),
        .o_ones  (ones)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op    <= s_axis_tuser;
            r_in_field <= s_axis_tdata[2:0];
            r_in_value <= s_axis_tdata[9:3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data  <= {res.day, res.month, res.year, res.second, res.minute,
                            res.hour, ones, tens, res.shown};
            r_out_field <= res.field;
            r_out_last  <= res.finished;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_field;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- verif/clock_calendar_set_menu_core_test.sv -----
// Self-checking stream testbench for the clock/calendar set-menu core.
module clock_calendar_set_menu_core_test;
    import ccsm_pkg::*;

    localparam logic [2:0] OP_RSVD5    = 3'd5;
    localparam logic [2:0] OP_RSVD6    = 3'd6;
    localparam logic [2:0] OP_RSVD7    = 3'd7;
    localparam logic [2:0] FIELD_RSVD7 = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         ITEMS_PER_PHASE = 430;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] field;
        logic [6:0] value;
    } t_menu_cmd;

    // Same bit order as {tlast, tuser, tdata}.
    typedef struct packed {
        logic       fin;
        logic [2:0] fld;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [3:0] ones;
        logic [3:0] tens;
        logic [6:0] shown;
    } t_menu_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // load_field[2:0], load_value[9:3], zero[15:10]
    logic [2:0]  s_axis_tuser = '0;   // opcode[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // shown, tens, ones, hour, minute, second, year, month, day
    logic [2:0]  m_axis_tuser;        // active_field[2:0]
    logic        m_axis_tlast;        // finished

    clock_calendar_set_menu_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predicted menu state
    logic [2:0] menu_pos = FIELD_IDLE;
    int         hour_q = 0;
    int         minute_q = 0;
    int         second_q = 0;
    int         year_q = 0;
    int         month_q = 1;
    int         day_q = 1;

    t_menu_cmd  pending_cmds[$];
    t_menu_res  expected_results[$];
    t_menu_cmd  next_cmd;
    t_menu_res  seen_res;
    t_menu_res  want_res;
    int         send_idle_pct = 37;
    int         recv_idle_pct = 66;
    int         issued_cmds = 0;
    int         accepted_cmds = 0;
    int         errors = 0;
    int         idle_cycles = 0;
    logic       cmd_taken = 1'b0;
    logic       res_taken = 1'b0;

    function automatic int days_in_month();
        if (month_q == 2) begin
            return (year_q % 4 == 0) ? 29 : 28;
        end
        if (month_q == 4 || month_q == 6 || month_q == 9 || month_q == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic int floor_of(logic [2:0] f);
        return (f == FIELD_MONTH || f == FIELD_DAY) ? 1 : 0;
    endfunction

    function automatic int ceiling_of(logic [2:0] f);
        case (f)
            FIELD_HOUR:                 return 23;
            FIELD_MINUTE, FIELD_SECOND: return 59;
            FIELD_YEAR:                 return 99;
            FIELD_MONTH:                return 12;
            default:                    return days_in_month();
        endcase
    endfunction

    function automatic int read_value(logic [2:0] f);
        case (f)
            FIELD_HOUR:   return hour_q;
            FIELD_MINUTE: return minute_q;
            FIELD_SECOND: return second_q;
            FIELD_YEAR:   return year_q;
            FIELD_MONTH:  return month_q;
            default:      return day_q;
        endcase
    endfunction

    function automatic void write_value(logic [2:0] f, int v);
        case (f)
            FIELD_HOUR:   hour_q = v;
            FIELD_MINUTE: minute_q = v;
            FIELD_SECOND: second_q = v;
            FIELD_YEAR:   year_q = v;
            FIELD_MONTH:  month_q = v;
            default:      day_q = v;
        endcase
    endfunction

    function automatic t_menu_res step_menu(logic [2:0] op, logic [2:0] lf, logic [6:0] lv);
        t_menu_res r;
        int        v;
        logic      in_menu;
        logic      fin;
        in_menu = (menu_pos < FIELD_IDLE);
        fin = 1'b0;
        if (op == OP_DOWN && in_menu) begin
            v = read_value(menu_pos);
            if (v > floor_of(menu_pos)) write_value(menu_pos, v - 1);
        end else if (op == OP_UP && in_menu) begin
            v = read_value(menu_pos);
            if (v < ceiling_of(menu_pos)) write_value(menu_pos, v + 1);
        end else if (op == OP_ADVANCE && in_menu) begin
            if (menu_pos == FIELD_DAY) begin
                menu_pos = FIELD_IDLE;
                fin = 1'b1;
            end else begin
                menu_pos = menu_pos + 3'd1;
            end
        end else if (op == OP_LOAD && lf < FIELD_IDLE) begin
            v = lv;
            if (v < floor_of(lf)) v = floor_of(lf);
            if (v > ceiling_of(lf)) v = ceiling_of(lf);
            write_value(lf, v);
        end else if (op == OP_START) begin
            menu_pos = FIELD_HOUR;
        end
        if (day_q > days_in_month()) day_q = days_in_month();
        v = (menu_pos < FIELD_IDLE) ? read_value(menu_pos) : 0;
        r.fin    = fin;
        r.fld    = menu_pos;
        r.shown  = v[6:0];
        r.tens   = 4'(v / 10);
        r.ones   = 4'(v % 10);
        r.hour   = hour_q[4:0];
        r.minute = minute_q[5:0];
        r.second = second_q[5:0];
        r.year   = year_q[6:0];
        r.month  = month_q[3:0];
        r.day    = day_q[4:0];
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic add_cmd(logic [2:0] op, logic [2:0] f, logic [6:0] v);
        t_menu_cmd c;
        c.op = op;
        c.field = f;
        c.value = v;
        pending_cmds.push_back(c);
        issued_cmds++;
    endtask

    function automatic logic [6:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 7'd0;
        if (r == 1) return 7'd127;
        if (r == 2) return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, 99));
    endfunction

    task automatic add_noise_cmd();
        add_cmd(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
    endtask

    task automatic add_edit_cmds(logic [2:0] f);
        int n;
        int r;
        logic [2:0] dir;
        if ($urandom_range(0, 9) == 0) begin
            dir = $urandom_range(0, 1) ? OP_UP : OP_DOWN;
            n = $urandom_range(20, 70);
            repeat (n) add_cmd(dir, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end else begin
            n = $urandom_range(0, 6);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 40) add_cmd(OP_UP, 3'($urandom_range(0, 7)), pick_value());
                else if (r < 80) add_cmd(OP_DOWN, 3'($urandom_range(0, 7)), pick_value());
                else if (r < 92) add_cmd(OP_LOAD, f, pick_value());
                else add_cmd(OP_LOAD, 3'($urandom_range(0, 7)), pick_value());
            end
        end
    endtask

    task automatic add_session();
        logic [2:0] f;
        add_cmd(OP_START, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        for (int i = 0; i < 6; i++) begin
            f = 3'(i);
            add_edit_cmds(f);
            if ($urandom_range(0, 19) == 0) begin
                add_cmd(OP_START, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
            end
            add_cmd(OP_ADVANCE, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
        end
    endtask

    task automatic add_random(int n);
        int goal;
        goal = issued_cmds + n;
        while (issued_cmds < goal) begin
            if ($urandom_range(0, 99) < 85) begin
                add_session();
            end else begin
                repeat ($urandom_range(1, 4)) add_noise_cmd();
            end
        end
    endtask

    task automatic add_directed();
        add_cmd(OP_UP, FIELD_HOUR, 7'd0);          // ignored while idle
        add_cmd(OP_ADVANCE, FIELD_DAY, 7'd127);
        add_cmd(OP_DOWN, FIELD_RSVD7, 7'd127);
        add_cmd(OP_RSVD5, FIELD_HOUR, 7'd5);
        add_cmd(OP_RSVD6, FIELD_RSVD7, 7'd127);
        add_cmd(OP_RSVD7, FIELD_MONTH, 7'd0);
        add_cmd(OP_LOAD, FIELD_RSVD7, 7'd127);
        add_cmd(OP_LOAD, FIELD_IDLE, 7'd50);
        add_cmd(OP_LOAD, FIELD_MONTH, 7'd0);       // saturates up to 1
        add_cmd(OP_LOAD, FIELD_DAY, 7'd0);
        add_cmd(OP_LOAD, FIELD_HOUR, 7'd127);
        add_cmd(OP_LOAD, FIELD_SECOND, 7'd60);
        add_cmd(OP_LOAD, FIELD_YEAR, 7'd127);
        add_cmd(OP_START, FIELD_HOUR, 7'd0);
        add_cmd(OP_UP, FIELD_HOUR, 7'd0);          // clamp at 23
        add_cmd(OP_ADVANCE, FIELD_HOUR, 7'd0);
        add_cmd(OP_DOWN, FIELD_HOUR, 7'd0);        // clamp at 0
        add_cmd(OP_START, FIELD_HOUR, 7'd0);       // restart keeps values
        add_cmd(OP_LOAD, FIELD_YEAR, 7'd0);
        add_cmd(OP_LOAD, FIELD_MONTH, 7'd2);
        add_cmd(OP_LOAD, FIELD_DAY, 7'd31);        // leap February: 29
        add_cmd(OP_LOAD, FIELD_YEAR, 7'd1);        // day pulled back to 28
        add_cmd(OP_LOAD, FIELD_MONTH, 7'd12);
        add_cmd(OP_LOAD, FIELD_DAY, 7'd31);
        add_cmd(OP_LOAD, FIELD_MONTH, 7'd4);       // day pulled back to 30
        repeat (5) add_cmd(OP_ADVANCE, FIELD_HOUR, 7'd0);
        add_cmd(OP_UP, FIELD_DAY, 7'd0);
        add_cmd(OP_ADVANCE, FIELD_HOUR, 7'd0);     // leaves the day field
    endtask

    task automatic drain_all();
        while (accepted_cmds != issued_cmds || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || cmd_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
                next_cmd = pending_cmds.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_cmd.op;
                s_axis_tdata  <= {6'b0, next_cmd.value, next_cmd.field};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(1, 100) > recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_taken = 1'b0;
            idle_cycles = 0;
        end else begin
            cmd_taken = s_axis_tvalid && s_axis_tready;
            res_taken = m_axis_tvalid && m_axis_tready;
            if (res_taken) begin
                seen_res = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result transaction with none expected, actual %h",
                             $time, seen_res);
                end else begin
                    want_res = expected_results.pop_front();
                    compare_field("active_field", want_res.fld, seen_res.fld);
                    compare_field("shown_value", want_res.shown, seen_res.shown);
                    compare_field("tens_digit", want_res.tens, seen_res.tens);
                    compare_field("ones_digit", want_res.ones, seen_res.ones);
                    compare_field("hour", want_res.hour, seen_res.hour);
                    compare_field("minute", want_res.minute, seen_res.minute);
                    compare_field("second", want_res.second, seen_res.second);
                    compare_field("year", want_res.year, seen_res.year);
                    compare_field("month", want_res.month, seen_res.month);
                    compare_field("day", want_res.day, seen_res.day);
                    compare_field("finished", want_res.fin, seen_res.fin);
                end
            end
            if (cmd_taken) begin
                expected_results.push_back(step_menu(s_axis_tuser, s_axis_tdata[2:0],
                                                     s_axis_tdata[9:3]));
                accepted_cmds++;
            end
            if (cmd_taken || res_taken) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 37;
        recv_idle_pct = 66;
        add_directed();
        add_random(ITEMS_PER_PHASE);
        drain_all();

        send_idle_pct = 66;
        recv_idle_pct = 37;
        add_random(ITEMS_PER_PHASE);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(ITEMS_PER_PHASE);
        drain_all();

        repeat (10) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
